[design/sjdm_pkg.sv]
package sjdm_pkg;

  // Line framing
  localparam int unsigned LineLen = 12;
  localparam int unsigned CntW    = 4;
  localparam logic [7:0]  ByteLf    = 8'd10;
  localparam logic [7:0]  ByteSpace = 8'd32;
  localparam logic [7:0]  ByteTab   = 8'd9;
  localparam logic [7:0]  ByteCr    = 8'd13;
  localparam logic [7:0]  BytePlus  = 8'd43;
  localparam logic [7:0]  ByteMinus = 8'd45;
  localparam logic [7:0]  ByteZero  = 8'd48;
  localparam logic [7:0]  ByteNine  = 8'd57;

  // Parsed value
  localparam int unsigned ValW = 17;
  typedef logic [ValW-1:0] val_t;
  localparam val_t ValMax = val_t'(99999);
  localparam val_t CmdMin = val_t'(4000);

  // Command queue
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);

  // Command codes
  localparam val_t TrigLeftBase  = val_t'(4000);
  localparam val_t TrigLeftLo    = val_t'(4045);
  localparam val_t TrigLeftHi    = val_t'(4255);
  localparam val_t TrigRightBase = val_t'(5000);
  localparam val_t TrigRightLo   = val_t'(5045);
  localparam val_t TrigRightHi   = val_t'(5255);
  localparam val_t SteerBase     = val_t'(6000);
  localparam val_t SteerLowHi    = val_t'(6118);
  localparam val_t SteerHighLo   = val_t'(6138);
  localparam val_t SteerHighHi   = val_t'(6255);
  localparam val_t ThrBase       = val_t'(7000);
  localparam val_t ThrLowHi      = val_t'(7118);
  localparam val_t ThrHighLo     = val_t'(7138);
  localparam val_t ThrHighHi     = val_t'(7255);

  localparam logic [7:0] StickMid    = 8'd128;
  localparam logic [7:0] DeadBandRst = 8'd50;

  // (128 - x) * 255 / 128, with y = 128 - x in 10..128
  function automatic logic [7:0] map_low(input logic [7:0] y);
    logic [15:0] prod;
    prod = ({y, 8'd0}) - {8'd0, y};
    return prod[14:7];
  endfunction

  // (x - 128) * 255 / 127, with y = x - 128 in 10..127: equals 2y, plus 1 at y = 127
  function automatic logic [7:0] map_high(input logic [6:0] y);
    return {y, 1'b0} + {7'd0, (y == 7'd127)};
  endfunction

  // Zero below the deadband, clamp at full scale
  function automatic logic [7:0] finish_wheel(input logic signed [9:0] w,
                                              input logic [7:0]        db);
    logic signed [9:0] dbs;
    dbs = $signed({2'b00, db});
    if (w < dbs) begin
      return 8'd0;
    end else if (w > 10'sd255) begin
      return 8'd255;
    end
    return w[7:0];
  endfunction

endpackage

[design/sjdm_parser.sv]
module sjdm_parser
  import sjdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output val_t       cmd_o
);

  typedef enum logic [1:0] {
    PhSkip,
    PhDigits,
    PhDone
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  val_t              val_q, val_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic        is_ws, is_sign, is_digit, line_end;
  logic [20:0] acc;

  assign is_ws    = (rx_byte_i == ByteSpace) ||
                    ((rx_byte_i >= ByteTab) && (rx_byte_i <= ByteCr));
  assign is_sign  = (rx_byte_i == BytePlus) || (rx_byte_i == ByteMinus);
  assign is_digit = (rx_byte_i >= ByteZero) && (rx_byte_i <= ByteNine);
  assign line_end = (rx_byte_i == ByteLf) || (cnt_q >= CntW'(LineLen - 1));

  // value * 10 + digit
  assign acc = {1'b0, val_q, 3'b000} + {3'b000, val_q, 1'b0} +
               {13'd0, rx_byte_i - ByteZero};

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    val_d   = val_q;
    cnt_d   = cnt_q;
    push_o  = 1'b0;
    if (accept_i) begin
      if (line_end) begin
        push_o  = !neg_q && (val_q > CmdMin);
        phase_d = PhSkip;
        neg_d   = 1'b0;
        val_d   = '0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
        case (phase_q)
          PhSkip: begin
            if (is_ws) begin
              phase_d = PhSkip;
            end else if (is_sign) begin
              neg_d   = (rx_byte_i == ByteMinus);
              phase_d = PhDigits;
            end else if (is_digit) begin
              val_d   = (acc > 21'(ValMax)) ? ValMax : acc[ValW-1:0];
              phase_d = PhDigits;
            end else begin
              phase_d = PhDone;
            end
          end
          PhDigits: begin
            if (is_digit) begin
              val_d = (acc > 21'(ValMax)) ? ValMax : acc[ValW-1:0];
            end else begin
              phase_d = PhDone;
            end
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  assign cmd_o = val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSkip;
      neg_q   <= 1'b0;
      val_q   <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      val_q   <= val_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[design/sjdm_cmd_fifo.sv]
module sjdm_cmd_fifo
  import sjdm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  val_t push_data_i,
  input  logic pop_i,
  output val_t pop_data_o,
  output logic full_o,
  output logic empty_o
);

  val_t             mem [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign full_o     = (count_q == (QPtrW + 1)'(QueueDepth));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPtrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPtrW + 1)'(1);
      end
    end
  end

endmodule

[design/sjdm_mixer.sv]
module sjdm_mixer
  import sjdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  val_t       cmd_i,
  input  logic [7:0] dead_band_i,
  output logic [7:0] left_drive_o,
  output logic [7:0] right_drive_o,
  output logic       left_dir_o,
  output logic       right_dir_o
);

  logic [7:0] base_q, base_d;
  logic       lpin_q, lpin_d;
  logic       rpin_q, rpin_d;
  logic [7:0] ldrv_q, rdrv_q;
  logic       ldir_q, rdir_q;

  logic trig_l, trig_r, thr_lo, thr_hi, str_lo, str_hi;
  val_t d4, d5, d6, d7;
  logic [7:0] m;
  logic signed [9:0] lw, rw;

  assign trig_l = (cmd_i >= TrigLeftLo)  && (cmd_i <= TrigLeftHi);
  assign trig_r = (cmd_i >= TrigRightLo) && (cmd_i <= TrigRightHi);
  assign thr_lo = (cmd_i >= ThrBase)     && (cmd_i <= ThrLowHi);
  assign thr_hi = (cmd_i >= ThrHighLo)   && (cmd_i <= ThrHighHi);
  assign str_lo = (cmd_i >= SteerBase)   && (cmd_i <= SteerLowHi);
  assign str_hi = (cmd_i >= SteerHighLo) && (cmd_i <= SteerHighHi);

  assign d4 = cmd_i - TrigLeftBase;
  assign d5 = cmd_i - TrigRightBase;
  assign d6 = cmd_i - SteerBase;
  assign d7 = cmd_i - ThrBase;

  always_comb begin
    base_d = base_q;
    lpin_d = lpin_q;
    rpin_d = rpin_q;
    m      = '0;
    if (trig_l) begin
      lpin_d = 1'b1;
      rpin_d = 1'b0;
      base_d = d4[7:0];
    end
    if (trig_r) begin
      lpin_d = 1'b0;
      rpin_d = 1'b1;
      base_d = d5[7:0];
    end
    if (thr_lo) begin
      lpin_d = 1'b1;
      rpin_d = 1'b0;
      base_d = map_low(StickMid - d7[7:0]);
    end else if (thr_hi) begin
      lpin_d = 1'b0;
      rpin_d = 1'b1;
      base_d = map_high(d7[6:0] - 7'(StickMid));
    end
    lw = $signed({2'b00, base_d});
    rw = $signed({2'b00, base_d});
    if (str_lo) begin
      m      = map_low(StickMid - d6[7:0]);
      lpin_d = 1'b0;
      lw     = lw - $signed({2'b00, m});
      rw     = rw + $signed({2'b00, m});
    end else if (str_hi) begin
      m      = map_high(d6[6:0] - 7'(StickMid));
      rpin_d = 1'b1;
      lw     = lw + $signed({2'b00, m});
      rw     = rw - $signed({2'b00, m});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      lpin_q <= 1'b0;
      rpin_q <= 1'b0;
    end else if (take_i) begin
      base_q <= base_d;
      lpin_q <= lpin_d;
      rpin_q <= rpin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      ldrv_q <= finish_wheel(lw, dead_band_i);
      rdrv_q <= finish_wheel(rw, dead_band_i);
      ldir_q <= lpin_d;
      rdir_q <= rpin_d;
    end
  end

  assign left_drive_o  = ldrv_q;
  assign right_drive_o = rdrv_q;
  assign left_dir_o    = ldir_q;
  assign right_dir_o   = rdir_q;

endmodule

[design/serial_joystick_drive_mixer.sv]
// Serial joystick drive mixer. Feed received serial bytes one beat at a time on
// the input channel; each line (ended by a line feed, or cut when it reaches the
// line length limit, which drops the byte that overflows) is read as a signed
// decimal number the way atoi reads it. A line whose value is above 4000 is a
// drive command and gives exactly one result beat with both wheel duties and
// both direction pin levels; any other line gives nothing. The block takes one
// byte per clock: the parser finishes each byte in the cycle it arrives, and a
// two-entry command queue sits in front of the mixer, so the input stalls only
// when that queue is full while results back up. A line's result is held in the
// queue, then in the output register when it is free. The deadband register is
// written through the config channel, which is always ready; write it only
// while no command is in flight. It resets to 50.
module serial_joystick_drive_mixer
  import sjdm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  // byte input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // drive result
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] left_drive_o,
  output logic [7:0] right_drive_o,
  output logic       left_dir_o,
  output logic       right_dir_o
);

  logic [7:0] dead_band_q;
  logic       in_accept;
  logic       push, pop;
  val_t       push_cmd, pop_cmd;
  logic       q_full, q_empty;
  logic       out_valid_q;

  assign cfg_ready_o = 1'b1;

  // Hold the deadband until software rewrites it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_band_q <= DeadBandRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dead_band_q <= cfg_data_i;
    end
  end

  // Stall the byte stream only while the command queue has no room
  assign in_stall_o = q_full;
  assign in_accept  = in_valid_i && !q_full;

  sjdm_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  sjdm_cmd_fifo u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Advance a command into the output register when it is empty or being drained
  assign pop = !q_empty && (!out_valid_q || !out_stall_i);

  sjdm_mixer u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (pop),
    .cmd_i         (pop_cmd),
    .dead_band_i   (dead_band_q),
    .left_drive_o  (left_drive_o),
    .right_drive_o (right_drive_o),
    .left_dir_o    (left_dir_o),
    .right_dir_o   (right_dir_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top
  import sjdm_pkg::*;
();

  // Parser phases of the line being received
  typedef enum logic [1:0] {LnSkip, LnDigits, LnDone} ln_phase_e;

  // One drive result beat
  typedef struct {
    logic [7:0] left;
    logic [7:0] right;
    logic       ldir;
    logic       rdir;
  } drive_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] left_drive;
  logic [7:0] right_drive;
  logic       left_dir;
  logic       right_dir;

  serial_joystick_drive_mixer u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .left_drive_o (left_drive),
    .right_drive_o(right_drive),
    .left_dir_o   (left_dir),
    .right_dir_o  (right_dir)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("tb_top: done, errors");
    $finish;
  end

  // Byte stream waiting for the driver, and drive beats still owed by the block
  logic [7:0] rx_pending_q[$];
  drive_t     drive_expect_q[$];
  int unsigned bytes_pushed = 0;
  int unsigned bytes_taken = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Shadow of the block: deadband register, line parser and drive state
  logic [7:0]  band_cfg = DeadBandRst;
  ln_phase_e   ln_phase = LnSkip;
  logic        ln_neg = 1'b0;
  logic [16:0] ln_value = '0;
  logic [3:0]  ln_count = '0;
  logic [7:0]  base_spd = '0;
  logic        lpin = 1'b0;
  logic        rpin = 1'b0;

  // Stick position below center mapped to 0..255 offset
  function automatic int stick_low(input int x);
    return ((128 - x) * 255) / 128;
  endfunction

  // Stick position above center mapped to 0..255 offset
  function automatic int stick_high(input int x);
    return ((x - 128) * 255) / 127;
  endfunction

  // Zero below the deadband, then clamp at full scale
  function automatic logic [7:0] wheel_out(input int w);
    if (w < int'(band_cfg)) return 8'd0;
    if (w > 255) return 8'd255;
    return w[7:0];
  endfunction

  // Advance the shadow parser by one accepted byte; queue a drive beat when a
  // line ends on a command value
  task automatic take_rx_byte(input logic [7:0] b);
    int     v, lw, rw, m, acc;
    logic   neg, is_ws, is_sign, took_sign;
    drive_t d;
    is_ws   = (b == ByteSpace) || (b >= ByteTab && b <= ByteCr);
    is_sign = (b == BytePlus) || (b == ByteMinus);
    if (b != ByteLf && int'(ln_count) < int'(LineLen) - 1) begin
      took_sign = 1'b0;
      if (ln_phase == LnSkip && !is_ws) begin
        ln_phase = LnDigits;
        if (is_sign) begin
          ln_neg    = (b == ByteMinus);
          took_sign = 1'b1;
        end
      end
      if (ln_phase == LnDigits && !took_sign) begin
        if (b >= ByteZero && b <= ByteNine) begin
          acc = int'(ln_value) * 10 + int'(b - ByteZero);
          ln_value = (acc > int'(ValMax)) ? ValMax : acc[16:0];
        end else begin
          ln_phase = LnDone;
        end
      end
      ln_count++;
    end else begin
      // Line ends here: on a length cut the byte itself is dropped
      v   = int'(ln_value);
      neg = ln_neg;
      ln_phase = LnSkip;
      ln_neg   = 1'b0;
      ln_value = '0;
      ln_count = '0;
      if (!neg && v > int'(CmdMin)) begin
        if (v >= int'(TrigLeftLo) && v <= int'(TrigLeftHi)) begin
          lpin = 1'b1;
          rpin = 1'b0;
          base_spd = 8'(v - int'(TrigLeftBase));
        end
        if (v >= int'(TrigRightLo) && v <= int'(TrigRightHi)) begin
          lpin = 1'b0;
          rpin = 1'b1;
          base_spd = 8'(v - int'(TrigRightBase));
        end
        if (v >= int'(ThrBase) && v <= int'(ThrLowHi)) begin
          lpin = 1'b1;
          rpin = 1'b0;
          base_spd = 8'(stick_low(v - int'(ThrBase)));
        end else if (v >= int'(ThrHighLo) && v <= int'(ThrHighHi)) begin
          lpin = 1'b0;
          rpin = 1'b1;
          base_spd = 8'(stick_high(v - int'(ThrBase)));
        end
        lw = int'(base_spd);
        rw = int'(base_spd);
        // Steering splits the offset between the wheels
        if (v >= int'(SteerBase) && v <= int'(SteerLowHi)) begin
          m = stick_low(v - int'(SteerBase));
          lpin = 1'b0;
          lw -= m;
          rw += m;
        end else if (v >= int'(SteerHighLo) && v <= int'(SteerHighHi)) begin
          m = stick_high(v - int'(SteerBase));
          rpin = 1'b1;
          lw += m;
          rw -= m;
        end
        d.left  = wheel_out(lw);
        d.right = wheel_out(rw);
        d.ldir  = lpin;
        d.rdir  = rpin;
        drive_expect_q.push_back(d);
      end
    end
  endtask

  // Byte driver: hold a beat while stalled, advance on acceptance, idle at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'd0;
    end else begin
      if (in_valid && !in_stall) begin
        take_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (rx_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_pending_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Result monitor: compare every accepted drive beat with the oldest expectation
  drive_t want_beat;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          $display("%0t: unexpected drive beat left %0d right %0d dirs %b%b", $time,
                   left_drive, right_drive, left_dir, right_dir);
          mismatches++;
        end else begin
          want_beat = drive_expect_q.pop_front();
          check_field("left_drive", want_beat.left, left_drive);
          check_field("right_drive", want_beat.right, right_drive);
          check_field("left_dir", want_beat.ldir, left_dir);
          check_field("right_dir", want_beat.rdir, right_dir);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_rx(input logic [7:0] b);
    rx_pending_q.push_back(b);
    bytes_pushed++;
  endtask

  task automatic push_text(input string s);
    foreach (s[k]) push_rx(s[k]);
  endtask

  // Pick a line value: mostly drive codes with their edges, some gaps and junk
  function automatic int unsigned pick_code();
    case ($urandom_range(11))
      0:       return $urandom_range(4045, 4255);
      1:       return $urandom_range(5045, 5255);
      2:       return $urandom_range(7000, 7118);
      3:       return $urandom_range(7138, 7255);
      4, 5:    return $urandom_range(6000, 6118);
      6, 7:    return $urandom_range(6138, 6255);
      8:       return $urandom_range(6000, 6255);
      9: begin
        case ($urandom_range(3))
          0:       return $urandom_range(4001, 4044);
          1:       return $urandom_range(4256, 5044);
          2:       return $urandom_range(7119, 7137);
          default: return $urandom_range(5256, 9999);
        endcase
      end
      10:      return $urandom_range(0, 4000);
      default: return $urandom_range(4001, 999999);
    endcase
  endfunction

  function automatic logic [7:0] pick_space();
    return ($urandom_range(1) == 0) ? ByteSpace : 8'($urandom_range(ByteTab, ByteCr));
  endfunction

  task automatic push_random_line();
    int unsigned pick, n;
    string digits;
    pick   = $urandom_range(99);
    digits = $sformatf("%0d", pick_code());
    if (pick < 74) begin
      // Well-formed command line, at most 10 bytes before the line feed
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n) push_rx(pick_space());
      if ($urandom_range(5) == 0) push_rx(($urandom_range(3) == 0) ? ByteMinus : BytePlus);
      push_text(digits);
      if ($urandom_range(7) == 0) push_rx(8'($urandom_range(255)));
      push_rx(ByteLf);
    end else if (pick < 88) begin
      // Raw noise over the whole byte range, line feed optional
      n = $urandom_range(0, 14);
      repeat (n) push_rx(8'($urandom_range(255)));
      if ($urandom_range(2) != 0) push_rx(ByteLf);
    end else begin
      // Padded line with trailing junk that may reach the length cut
      n = $urandom_range(4, 10);
      repeat (n) push_rx(pick_space());
      push_text(digits);
      push_text("x9");
      push_rx(ByteLf);
    end
  endtask

  task automatic push_random(input int unsigned nbytes);
    int unsigned start;
    start = bytes_pushed;
    while (bytes_pushed - start < nbytes) push_random_line();
  endtask

  // Hold off until every byte is taken and every drive beat has come back
  task automatic drain();
    while (bytes_taken != bytes_pushed || drive_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dead_band(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    band_cfg = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 37;
    recv_idle_pct = 57;

    // Directed lines at the reset deadband
    push_text("4045\n");          // trigger low edge, under the deadband
    push_text("4255\n");
    push_text("5045\n");
    push_text("5255\n");
    push_text("7000\n");          // throttle extremes and the center gap edges
    push_text("7118\n");
    push_text("7138\n");
    push_text("7255\n");
    push_text("4200\n");
    push_text("6000\n");          // full steer: one wheel under zero, one over 255
    push_text("6118\n");
    push_text("6138\n");
    push_text("6255\n");
    push_text("6128\n");          // other code: result from stored state
    push_text("4000\n");          // not a command
    push_text("4001\n");
    push_text(" \t+4100\n");      // whitespace and a plus sign
    push_text("-4100\n");         // negative value
    push_text("+-4100\n");        // second sign ends the number
    push_text("4150x99\n");       // trailing junk
    push_text("999999\n");        // saturates, then acts as another code
    push_text("      4230ABCD\n"); // cut at the length limit, drop the overflow byte
    push_text("\n");              // empty line
    push_text("4150");            // null byte ends the number
    push_rx(8'd0);
    push_text("7\n");
    drain();

    write_dead_band(8'd0);
    push_random(300);
    drain();
    write_dead_band(8'd255);
    push_random(150);
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 37;
    write_dead_band(8'($urandom_range(1, 254)));
    push_random(250);
    // Stop feeding until every owed beat is back, then resume
    drain();
    push_random(200);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_dead_band(8'($urandom_range(20, 120)));
    push_random(380);
    drain();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && drive_expect_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
design/sjdm_pkg.sv
design/sjdm_parser.sv
design/sjdm_cmd_fifo.sv
design/sjdm_mixer.sv
design/serial_joystick_drive_mixer.sv
bench/tb_top.sv
